// ----- rtl/core/b2d_pkg.sv -----
// Shared types and constants for the binary to decimal digit converter.
`timescale 1ns / 1ps

package b2d_pkg;

  // Input transfer: one signed 128-bit value as two 64-bit words.
  typedef struct packed {
    logic signed [63:0] value_high;
    logic        [63:0] value_low;
  } req_t;

  // Output transfer: one symbol of the decimal run.
  typedef struct packed {
    logic [3:0] symbol;
    logic       final_symbol;
  } sym_t;

  // Commands broadcast to every digit cell.
  typedef struct packed {
    logic clear;    // load zero
    logic dabble;   // adjust and shift one binary bit in
    logic advance;  // move digits one cell toward the top
  } cell_cmd_t;

  localparam logic [3:0] MINUS_SYMBOL = 4'd10;
  localparam logic [3:0] ADJ_LIMIT    = 4'd5;
  localparam logic [3:0] ADJ_ADD      = 4'd3;

endpackage

// ----- rtl/core/b2d_cell.sv -----
// One BCD digit cell of the shift-and-add-3 chain.
`timescale 1ns / 1ps

module b2d_cell (
  input  logic                 clk,
  input  b2d_pkg::cell_cmd_t   cmd,
  input  logic                 bin_in,
  input  logic [3:0]           dig_in,
  output logic                 carry_out,
  output logic [3:0]           digit
);

  logic [3:0] adj;

  // Add three ahead of the doubling so the digit carries at ten.
  assign adj       = (digit >= b2d_pkg::ADJ_LIMIT) ? (digit + b2d_pkg::ADJ_ADD) : digit;
  assign carry_out = adj[3];

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      digit <= 4'd0;
    end else if (cmd.dabble) begin
      digit <= {adj[2:0], bin_in};
    end else if (cmd.advance) begin
      digit <= dig_in;
    end
  end

endmodule

// ----- rtl/core/binary_to_decimal_digits.sv -----
// Top level: signed binary value to a run of decimal symbols.
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  b2d_pkg::req_t (value_high, value_low)
// sym      out        sym_valid/sym_stall  b2d_pkg::sym_t (symbol, final_symbol)
//
// An item is loaded, then shifted bit by bit by shift-and-add-3 into the row of NDIG
// digit cells (one bit per cycle); a negative item then gets a minus symbol, and the
// digits are walked out of the top cell (leading zeros dropped, one per cycle).
// Reset (rst, synchronous) returns the sequencer to idle and empties the output register.
// A stall on sym holds the walk; req is stalled from acceptance until the last symbol
// is loaded into the output register.

module binary_to_decimal_digits #(
  parameter int VALUE_BITS = 128
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  b2d_pkg::req_t  req,
  output logic           sym_valid,
  input  logic           sym_stall,
  output b2d_pkg::sym_t  sym
);

  // Digits of 2**VALUE_BITS; log10(2) ~ 1233/4096.
  localparam int NDIG   = ((VALUE_BITS * 1233) / 4096) + 1;
  localparam int CNT_W  = $clog2(NDIG + 1);
  localparam int BIT_W  = $clog2(VALUE_BITS + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SHIFT = 4'b0010,
    S_SIGN  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t                  state, state_next;
  logic [VALUE_BITS-1:0]   mag;          // magnitude still to be shifted in
  logic                    negative;
  logic [BIT_W-1:0]        bits_left;
  logic [CNT_W-1:0]        remaining;    // digits still held in the chain
  logic                    leading;      // no digit emitted yet for this item

  logic [VALUE_BITS-1:0]   fitted;
  logic [VALUE_BITS-1:0]   fitted_mag;
  logic                    req_xfer;
  logic                    slot_free;
  logic                    load_sym;
  b2d_pkg::sym_t           sym_next;
  b2d_pkg::cell_cmd_t      cmd;

  logic [NDIG-1:0]         carry;
  logic [3:0]              digit [NDIG];
  logic [3:0]              top_digit;
  logic                    skip_zero;

  // Keep the low VALUE_BITS bits; the top one of them is the sign.
  assign fitted     = VALUE_BITS'({req.value_high, req.value_low});
  assign fitted_mag = fitted[VALUE_BITS-1] ? (~fitted + VALUE_BITS'(1)) : fitted;

  assign req_stall = (state != S_IDLE);
  assign req_xfer  = req_valid && !req_stall;
  assign slot_free = !sym_valid || !sym_stall;

  // Only zeros ahead of the first emitted digit are dropped; the last digit always goes.
  assign top_digit = digit[NDIG-1];
  assign skip_zero = leading && (top_digit == 4'd0) && (remaining > CNT_W'(1));

  // Row of digit cells; data moves toward the top in both modes.
  for (genvar i = 0; i < NDIG; i++) begin : g_cell
    if (i == 0) begin : g_first
      b2d_cell u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .bin_in    (mag[VALUE_BITS-1]),
        .dig_in    (4'd0),
        .carry_out (carry[i]),
        .digit     (digit[i])
      );
    end else begin : g_rest
      b2d_cell u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .bin_in    (carry[i-1]),
        .dig_in    (digit[i-1]),
        .carry_out (carry[i]),
        .digit     (digit[i])
      );
    end
  end

  // Sequencer: pick the cell command, the next state and any symbol to load.
  always_comb begin
    state_next = state;
    cmd        = '0;
    load_sym   = 1'b0;
    sym_next   = '0;
    case (state)
      S_IDLE: begin
        if (req_xfer) begin
          cmd.clear  = 1'b1;
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.dabble = 1'b1;
        if (bits_left == BIT_W'(1)) begin
          state_next = negative ? S_SIGN : S_EMIT;
        end
      end
      S_SIGN: begin
        if (slot_free) begin
          load_sym            = 1'b1;
          sym_next.symbol     = b2d_pkg::MINUS_SYMBOL;
          sym_next.final_symbol = 1'b0;
          state_next          = S_EMIT;
        end
      end
      S_EMIT: begin
        if (skip_zero) begin
          // Drop a leading zero without producing a symbol.
          cmd.advance = 1'b1;
        end else if (slot_free) begin
          cmd.advance           = 1'b1;
          load_sym              = 1'b1;
          sym_next.symbol       = top_digit;
          sym_next.final_symbol = (remaining == CNT_W'(1));
          if (remaining == CNT_W'(1)) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sym_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_sym) begin
        sym_valid <= 1'b1;
      end else if (slot_free) begin
        sym_valid <= 1'b0;
      end
    end
  end

  // Datapath registers: magnitude, sign, counters and the output symbol.
  always_ff @(posedge clk) begin
    if (load_sym) begin
      sym <= sym_next;
    end
    if (req_xfer) begin
      leading <= 1'b1;
    end else if (load_sym && (state == S_EMIT)) begin
      leading <= 1'b0;
    end
    if (req_xfer) begin
      mag       <= fitted_mag;
      negative  <= fitted[VALUE_BITS-1];
      bits_left <= BIT_W'(VALUE_BITS);
      remaining <= CNT_W'(NDIG);
    end else if (state == S_SHIFT) begin
      mag       <= {mag[VALUE_BITS-2:0], 1'b0};
      bits_left <= bits_left - BIT_W'(1);
    end else if (cmd.advance) begin
      remaining <= remaining - CNT_W'(1);
    end
  end

`ifndef SYNTHESIS
  a_count_held_in_shift : assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> (remaining == CNT_W'(NDIG)))
    else $error("digit count moved during conversion");

  a_emit_has_digits : assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (remaining != CNT_W'(0)))
    else $error("emit phase with no digits left");

  a_minus_not_final : assert property (@(posedge clk) disable iff (rst)
    (sym_valid && (sym.symbol == b2d_pkg::MINUS_SYMBOL)) |-> !sym.final_symbol)
    else $error("minus sign flagged as final symbol");

  a_symbol_range : assert property (@(posedge clk) disable iff (rst)
    sym_valid |-> (sym.symbol <= b2d_pkg::MINUS_SYMBOL))
    else $error("symbol code out of range");

  a_final_ends_item : assert property (@(posedge clk) disable iff (rst)
    (load_sym && sym_next.final_symbol) |=> (state == S_IDLE))
    else $error("last symbol loaded but sequencer not idle");
`endif

endmodule
